// ===== rtl/fpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flight phase detector package
// Shared types, phase codes, register indexes and fixed hold times.
// ----------------------------------------------------------------------------
package fpd_pkg;

    // Widths of the poll and result fields.
    localparam int LEVEL_W = 16;
    localparam int TICK_W  = 32;
    localparam int PHASE_W = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Hold times of the later detect phases, in ticks.
    localparam logic [TICK_W-1:0] APOGEE_HOLD_TICKS  = 32'd1000;
    localparam logic [TICK_W-1:0] DROGUE_HOLD_TICKS  = 32'd1000;
    localparam logic [TICK_W-1:0] MAIN_HOLD_TICKS    = 32'd1000;
    localparam logic [TICK_W-1:0] LANDING_HOLD_TICKS = 32'd1000;

    // Flight phases.
    typedef enum logic [PHASE_W-1:0] {
        PH_INIT           = 4'd0,
        PH_IDLE           = 4'd1,
        PH_LAUNCH_DETECT  = 4'd2,
        PH_BOOST          = 4'd3,
        PH_BURNOUT_DETECT = 4'd4,
        PH_COAST          = 4'd5,
        PH_APOGEE_DETECT  = 4'd6,
        PH_APOGEE         = 4'd7,
        PH_DROGUE_DETECT  = 4'd8,
        PH_DROGUE         = 4'd9,
        PH_MAIN_DETECT    = 4'd10,
        PH_MAIN           = 4'd11,
        PH_LANDED_DETECT  = 4'd12,
        PH_LANDED         = 4'd13
    } phase_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LAUNCH_ACCEL_LEVEL = 3'd0,
        REG_LAUNCH_HOLD_TICKS  = 3'd1,
        REG_COAST_ACCEL_LEVEL  = 3'd2,
        REG_COAST_HOLD_TICKS   = 3'd3,
        REG_APOGEE_VEL_LEVEL   = 3'd4,
        REG_DROGUE_VEL_LEVEL   = 3'd5,
        REG_MAIN_VEL_LEVEL     = 3'd6,
        REG_LANDED_VEL_LEVEL   = 3'd7
    } cfg_index_t;

    // Current configuration as seen by the phase logic.
    typedef struct packed {
        logic signed [LEVEL_W-1:0] launch_accel_level;
        logic        [TICK_W-1:0]  launch_hold_ticks;
        logic signed [LEVEL_W-1:0] coast_accel_level;
        logic        [TICK_W-1:0]  coast_hold_ticks;
        logic signed [LEVEL_W-1:0] apogee_vel_level;
        logic signed [LEVEL_W-1:0] drogue_vel_level;
        logic signed [LEVEL_W-1:0] main_vel_level;
        logic signed [LEVEL_W-1:0] landed_vel_level;
    } cfg_t;

    // One registered poll word.
    typedef struct packed {
        logic                      gps_locked;
        logic signed [LEVEL_W-1:0] accel_z;
        logic signed [LEVEL_W-1:0] vel_z;
        logic        [TICK_W-1:0]  now_ticks;
    } poll_t;

    // Result of one poll.
    typedef struct packed {
        phase_t phase;
        logic   phase_changed;
    } result_t;

endpackage

// ===== rtl/fpd_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flight phase detector configuration registers
// Write-only register file holding the thresholds and hold times.
// ----------------------------------------------------------------------------
module fpd_cfg_regs
    import fpd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write into the addressed field.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_LAUNCH_ACCEL_LEVEL: cfg_next.launch_accel_level = cfg_wdata[LEVEL_W-1:0];
                REG_LAUNCH_HOLD_TICKS:  cfg_next.launch_hold_ticks  = cfg_wdata[TICK_W-1:0];
                REG_COAST_ACCEL_LEVEL:  cfg_next.coast_accel_level  = cfg_wdata[LEVEL_W-1:0];
                REG_COAST_HOLD_TICKS:   cfg_next.coast_hold_ticks   = cfg_wdata[TICK_W-1:0];
                REG_APOGEE_VEL_LEVEL:   cfg_next.apogee_vel_level   = cfg_wdata[LEVEL_W-1:0];
                REG_DROGUE_VEL_LEVEL:   cfg_next.drogue_vel_level   = cfg_wdata[LEVEL_W-1:0];
                REG_MAIN_VEL_LEVEL:     cfg_next.main_vel_level     = cfg_wdata[LEVEL_W-1:0];
                REG_LANDED_VEL_LEVEL:   cfg_next.landed_vel_level   = cfg_wdata[LEVEL_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    // Register file with the power-on thresholds.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.launch_accel_level <= 16'sd768;
            cfg_reg.launch_hold_ticks  <= 32'd1000;
            cfg_reg.coast_accel_level  <= 16'sd0;
            cfg_reg.coast_hold_ticks   <= 32'd1000;
            cfg_reg.apogee_vel_level   <= 16'sd0;
            cfg_reg.drogue_vel_level   <= 16'sd0;
            cfg_reg.main_vel_level     <= 16'sd0;
            cfg_reg.landed_vel_level   <= 16'sd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/fpd_phase_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flight phase detector phase core
// Holds the current phase and detect start tick and steps them once per word.
// ----------------------------------------------------------------------------
module fpd_phase_core
    import fpd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  poll_t   poll,
    input  cfg_t    cfg,
    output result_t result,
    output phase_t  cur_phase
);

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [TICK_W-1:0] start_reg;
    logic [TICK_W-1:0] start_next;
    logic [TICK_W-1:0] elapsed;
    logic              enter;

    // Ticks since the detect phase was entered, modulo the tick width.
    assign elapsed = poll.now_ticks - start_reg;

    // Next phase: strict compares (signed levels, unsigned ticks), fall back before hold check.
    always_comb
    begin
        phase_next = phase_reg;
        enter      = 1'b0;
        unique case (phase_reg)
            PH_INIT:
                if (poll.gps_locked) phase_next = PH_IDLE;
            PH_IDLE:
                if (poll.accel_z > cfg.launch_accel_level)
                begin
                    phase_next = PH_LAUNCH_DETECT;
                    enter      = 1'b1;
                end
            PH_LAUNCH_DETECT:
                priority if (poll.accel_z < cfg.launch_accel_level) phase_next = PH_IDLE;
                else if (elapsed > cfg.launch_hold_ticks) phase_next = PH_BOOST;
                else phase_next = phase_reg;
            PH_BOOST:
                if (poll.accel_z < cfg.coast_accel_level)
                begin
                    phase_next = PH_BURNOUT_DETECT;
                    enter      = 1'b1;
                end
            PH_BURNOUT_DETECT:
                priority if (poll.accel_z > cfg.coast_accel_level) phase_next = PH_BOOST;
                else if (elapsed > cfg.coast_hold_ticks) phase_next = PH_COAST;
                else phase_next = phase_reg;
            PH_COAST:
                if (poll.vel_z < cfg.apogee_vel_level)
                begin
                    phase_next = PH_APOGEE_DETECT;
                    enter      = 1'b1;
                end
            PH_APOGEE_DETECT:
                priority if (poll.vel_z > cfg.apogee_vel_level) phase_next = PH_COAST;
                else if (elapsed > APOGEE_HOLD_TICKS) phase_next = PH_APOGEE;
                else phase_next = phase_reg;
            PH_APOGEE:
                if (poll.vel_z > cfg.drogue_vel_level)
                begin
                    phase_next = PH_DROGUE_DETECT;
                    enter      = 1'b1;
                end
            PH_DROGUE_DETECT:
                priority if (poll.vel_z < cfg.drogue_vel_level) phase_next = PH_APOGEE;
                else if (elapsed > DROGUE_HOLD_TICKS) phase_next = PH_DROGUE;
                else phase_next = phase_reg;
            PH_DROGUE:
                if (poll.vel_z > cfg.main_vel_level)
                begin
                    phase_next = PH_MAIN_DETECT;
                    enter      = 1'b1;
                end
            PH_MAIN_DETECT:
                priority if (poll.vel_z < cfg.main_vel_level) phase_next = PH_DROGUE;
                else if (elapsed > MAIN_HOLD_TICKS) phase_next = PH_MAIN;
                else phase_next = phase_reg;
            PH_MAIN:
                if (poll.vel_z > cfg.landed_vel_level)
                begin
                    phase_next = PH_LANDED_DETECT;
                    enter      = 1'b1;
                end
            PH_LANDED_DETECT:
                priority if (poll.vel_z < cfg.landed_vel_level) phase_next = PH_MAIN;
                else if (elapsed > LANDING_HOLD_TICKS) phase_next = PH_LANDED;
                else phase_next = phase_reg;
            // Landed is final; unused codes hold.
            default:
                phase_next = phase_reg;
        endcase
    end

    // Detect start tick is captured on entry to a detect phase.
    assign start_next = enter ? poll.now_ticks : start_reg;

    // State registers advance only when a word is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_INIT;
            start_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            start_reg <= start_next;
        end
    end

    assign result.phase         = phase_next;
    assign result.phase_changed = (phase_next != phase_reg);
    assign cur_phase            = phase_reg;

endmodule

// ===== rtl/flight_phase_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flight phase detector
// A word accepted into the input register goes to the result register when
// that register is free. Throughput: one word per cycle while out_stall is
// low; the phase and detect start tick registers are the only loop.
// Reset: rst_n clears the phase to init, the detect start tick to zero, both
// pipeline valids, and loads the default thresholds and hold times.
// ----------------------------------------------------------------------------
module flight_phase_detector
    import fpd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // Configuration write port
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata,
    // Poll channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      gps_locked,
    input  logic signed [LEVEL_W-1:0] accel_z,
    input  logic signed [LEVEL_W-1:0] vel_z,
    input  logic [TICK_W-1:0]         now_ticks,
    // Result channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [PHASE_W-1:0]        phase,
    output logic                      phase_changed
);

    cfg_t    cfg;
    poll_t   poll_reg;
    poll_t   poll_next;
    logic    in_valid_reg;
    logic    in_valid_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t result_reg;
    result_t result_next;
    result_t core_result;
    phase_t  cur_phase;
    logic    out_free;
    logic    step;
    logic    in_take;

    fpd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    fpd_phase_core u_phase_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .poll      (poll_reg),
        .cfg       (cfg),
        .result    (core_result),
        .cur_phase (cur_phase)
    );

    // Handshake: the result register frees when empty or being taken.
    assign out_free = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    // Input register next values.
    always_comb
    begin
        poll_next.gps_locked = gps_locked;
        poll_next.accel_z    = accel_z;
        poll_next.vel_z      = vel_z;
        poll_next.now_ticks  = now_ticks;
        priority if (in_take) in_valid_next = 1'b1;
        else if (step)        in_valid_next = 1'b0;
        else                  in_valid_next = in_valid_reg;
    end

    // Result register next values.
    always_comb
    begin
        result_next = core_result;
        priority if (step)    out_valid_next = 1'b1;
        else if (!out_stall)  out_valid_next = 1'b0;
        else                  out_valid_next = out_valid_reg;
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            poll_reg <= poll_next;
        end
        if (step)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign phase         = result_reg.phase;
    assign phase_changed = result_reg.phase_changed;

    // The phase only moves when a word is processed.
    a_phase_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(cur_phase))
        else $error("phase changed without a word being processed");

    // Landed is final.
    a_landed_final: assert property (@(posedge clk) disable iff (!rst_n)
        cur_phase == PH_LANDED |=> cur_phase == PH_LANDED)
        else $error("phase left landed");

    // A reported change never lands back in init.
    a_change_not_init: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && phase_changed |-> phase != PH_INIT)
        else $error("phase change reported into init");

    // Stall is only raised while a word waits in the input register.
    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && out_valid_reg)
        else $error("input stalled with no word waiting");

endmodule

// ===== bench/flight_phase_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flight phase checker
// Watches the configuration port and both word channels of the flight phase
// detector. It keeps its own copy of the thresholds, the phase and the detect
// start tick, and predicts the phase word for every accepted poll. Each
// accepted result word is compared field by field with the oldest
// prediction. The mismatch count and the number of words still owed go back
// to the bench top.
// ----------------------------------------------------------------------------
module flight_phase_checker
    import fpd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic                      gps_locked,
    input  logic signed [LEVEL_W-1:0] accel_z,
    input  logic signed [LEVEL_W-1:0] vel_z,
    input  logic [TICK_W-1:0]         now_ticks,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic [PHASE_W-1:0]        phase,
    input  logic                      phase_changed,
    output int                        mismatch_count,
    output int                        pending_words
);

    // Threshold copy, loaded from the write port.
    logic signed [LEVEL_W-1:0] launch_level;
    logic        [TICK_W-1:0]  launch_hold;
    logic signed [LEVEL_W-1:0] coast_level;
    logic        [TICK_W-1:0]  coast_hold;
    logic signed [LEVEL_W-1:0] apogee_level;
    logic signed [LEVEL_W-1:0] drogue_level;
    logic signed [LEVEL_W-1:0] main_level;
    logic signed [LEVEL_W-1:0] landed_level;

    // Predicted sequencer state.
    phase_t            flight_phase;
    logic [TICK_W-1:0] detect_start;

    // Phase words predicted but not yet seen on the result channel.
    result_t predicted_phases[$];
    result_t forecast;

    // Advance the predicted sequencer by one poll and queue the word it gives.
    task automatic step_flight_phase(
        input logic                      lock,
        input logic signed [LEVEL_W-1:0] az,
        input logic signed [LEVEL_W-1:0] vz,
        input logic [TICK_W-1:0]         now
    );
        phase_t            next_phase;
        logic [TICK_W-1:0] elapsed;
        logic              entered;
        result_t           word;
        elapsed    = now - detect_start;
        next_phase = flight_phase;
        entered    = 1'b0;
        case (flight_phase)
            PH_INIT:
                if (lock)
                    next_phase = PH_IDLE;
            PH_IDLE:
                if (az > launch_level)
                begin
                    next_phase = PH_LAUNCH_DETECT;
                    entered    = 1'b1;
                end
            PH_LAUNCH_DETECT:
                if (az < launch_level)
                    next_phase = PH_IDLE;
                else if (elapsed > launch_hold)
                    next_phase = PH_BOOST;
            PH_BOOST:
                if (az < coast_level)
                begin
                    next_phase = PH_BURNOUT_DETECT;
                    entered    = 1'b1;
                end
            PH_BURNOUT_DETECT:
                if (az > coast_level)
                    next_phase = PH_BOOST;
                else if (elapsed > coast_hold)
                    next_phase = PH_COAST;
            PH_COAST:
                if (vz < apogee_level)
                begin
                    next_phase = PH_APOGEE_DETECT;
                    entered    = 1'b1;
                end
            PH_APOGEE_DETECT:
                if (vz > apogee_level)
                    next_phase = PH_COAST;
                else if (elapsed > APOGEE_HOLD_TICKS)
                    next_phase = PH_APOGEE;
            PH_APOGEE:
                if (vz > drogue_level)
                begin
                    next_phase = PH_DROGUE_DETECT;
                    entered    = 1'b1;
                end
            PH_DROGUE_DETECT:
                if (vz < drogue_level)
                    next_phase = PH_APOGEE;
                else if (elapsed > DROGUE_HOLD_TICKS)
                    next_phase = PH_DROGUE;
            PH_DROGUE:
                if (vz > main_level)
                begin
                    next_phase = PH_MAIN_DETECT;
                    entered    = 1'b1;
                end
            PH_MAIN_DETECT:
                if (vz < main_level)
                    next_phase = PH_DROGUE;
                else if (elapsed > MAIN_HOLD_TICKS)
                    next_phase = PH_MAIN;
            PH_MAIN:
                if (vz > landed_level)
                begin
                    next_phase = PH_LANDED_DETECT;
                    entered    = 1'b1;
                end
            PH_LANDED_DETECT:
                if (vz < landed_level)
                    next_phase = PH_MAIN;
                else if (elapsed > LANDING_HOLD_TICKS)
                    next_phase = PH_LANDED;
            // Landed is final.
            default: ;
        endcase
        if (entered)
            detect_start = now;
        word.phase         = next_phase;
        word.phase_changed = (next_phase != flight_phase);
        flight_phase       = next_phase;
        predicted_phases.push_back(word);
    endtask

    // Everything is sampled at the rising edge, before the edge's updates land.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            launch_level = 16'sd768;
            launch_hold  = 32'd1000;
            coast_level  = '0;
            coast_hold   = 32'd1000;
            apogee_level = '0;
            drogue_level = '0;
            main_level   = '0;
            landed_level = '0;
            flight_phase = PH_INIT;
            detect_start = '0;
            predicted_phases.delete();
            pending_words = 0;
        end
        else
        begin
            // Register writes only happen while no poll is in flight.
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    REG_LAUNCH_ACCEL_LEVEL: launch_level = cfg_wdata[LEVEL_W-1:0];
                    REG_LAUNCH_HOLD_TICKS:  launch_hold  = cfg_wdata[TICK_W-1:0];
                    REG_COAST_ACCEL_LEVEL:  coast_level  = cfg_wdata[LEVEL_W-1:0];
                    REG_COAST_HOLD_TICKS:   coast_hold   = cfg_wdata[TICK_W-1:0];
                    REG_APOGEE_VEL_LEVEL:   apogee_level = cfg_wdata[LEVEL_W-1:0];
                    REG_DROGUE_VEL_LEVEL:   drogue_level = cfg_wdata[LEVEL_W-1:0];
                    REG_MAIN_VEL_LEVEL:     main_level   = cfg_wdata[LEVEL_W-1:0];
                    REG_LANDED_VEL_LEVEL:   landed_level = cfg_wdata[LEVEL_W-1:0];
                    default: ;
                endcase
            end

            // Result words are matched before this edge's poll is predicted.
            if (out_valid && !out_stall)
            begin
                if (predicted_phases.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result word with nothing predicted, got phase %0d changed %0b",
                             $time, phase, phase_changed);
                end
                else
                begin
                    forecast = predicted_phases.pop_front();
                    if (phase !== forecast.phase)
                    begin
                        mismatch_count++;
                        $display("%0t: phase mismatch, expected %0d, got %0d",
                                 $time, forecast.phase, phase);
                    end
                    if (phase_changed !== forecast.phase_changed)
                    begin
                        mismatch_count++;
                        $display("%0t: phase_changed mismatch, expected %0b, got %0b",
                                 $time, forecast.phase_changed, phase_changed);
                    end
                end
            end

            if (in_valid && !in_stall)
                step_flight_phase(gps_locked, accel_z, vel_z, now_ticks);

            pending_words = predicted_phases.size();
        end
    end

endmodule

// ===== bench/flight_phase_detector_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flight phase detector bench
// Drives polls into the detector through one simulated flight: a short
// directed run on the reset thresholds, then random polls steered toward the
// next phase at a paced rate, mixed with polls that hover on the thresholds
// and plain noise. Four threshold settings are loaded between stretches,
// two of them at the field extremes. The checker module does the prediction.
// ----------------------------------------------------------------------------
module flight_phase_detector_test
    import fpd_pkg::*;
();

    localparam int RANDOM_POLLS = 1600;
    localparam int STRETCH_LEN  = 400;
    localparam int CALM_FROM    = 1450;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = 16'sh8000;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 16'sh7FFF;
    localparam logic [TICK_W-1:0]         TICKS_MAX = 32'hFFFF_FFFF;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_wdata = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      gps_locked = 1'b0;
    logic signed [LEVEL_W-1:0] accel_z = '0;
    logic signed [LEVEL_W-1:0] vel_z = '0;
    logic [TICK_W-1:0]         now_ticks = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [PHASE_W-1:0]        phase;
    logic                      phase_changed;

    int mismatch_count;
    int pending_words;
    int cycle_count;
    int stall_left = 0;
    logic calm = 1'b0;

    // Thresholds currently loaded, used only to aim the polls.
    logic signed [LEVEL_W-1:0] launch_lvl = 16'sd768;
    logic signed [LEVEL_W-1:0] coast_lvl  = '0;
    logic signed [LEVEL_W-1:0] apogee_lvl = '0;
    logic signed [LEVEL_W-1:0] drogue_lvl = '0;
    logic signed [LEVEL_W-1:0] main_lvl   = '0;
    logic signed [LEVEL_W-1:0] landed_lvl = '0;

    // Last phase seen on the result channel and the running tick count.
    phase_t            seen_phase = PH_INIT;
    logic [TICK_W-1:0] tick_now = '0;

    flight_phase_detector dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .gps_locked    (gps_locked),
        .accel_z       (accel_z),
        .vel_z         (vel_z),
        .now_ticks     (now_ticks),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .phase         (phase),
        .phase_changed (phase_changed)
    );

    flight_phase_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .gps_locked     (gps_locked),
        .accel_z        (accel_z),
        .vel_z          (vel_z),
        .now_ticks      (now_ticks),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .phase          (phase),
        .phase_changed  (phase_changed),
        .mismatch_count (mismatch_count),
        .pending_words  (pending_words)
    );

    // 4 ns clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // The result side stalls in random bursts, except at the end.
    always @(posedge clk)
    begin
        if (calm)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 12);
        end
        else
            out_stall <= 1'b0;
    end

    // Track the flight as the detector reports it, to aim the next polls.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            seen_phase <= phase_t'(phase);
    end

    // Give up on a hung or runaway run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Pick a value on or across a threshold. A hovering value lands within
    // one step of the level; a pushing value crosses it in the given
    // direction, or sits on it when that is enough to hold a detect phase.
    function automatic logic signed [LEVEL_W-1:0] steer(
        input logic signed [LEVEL_W-1:0] lv,
        input logic                      up,
        input logic                      eq_ok,
        input logic                      push
    );
        int v;
        int span;
        span = up ? 32767 - int'(lv) : int'(lv) + 32768;
        if (!push || span == 0)
            v = int'(lv) + int'($urandom_range(0, 2)) - 1;
        else if (eq_ok && $urandom_range(0, 3) == 0)
            v = lv;
        else if ($urandom_range(0, 1) == 0)
            v = up ? int'(lv) + 1 : int'(lv) - 1;
        else if (up)
            v = int'(lv) + 1 + int'($urandom_range(0, span - 1));
        else
            v = int'(lv) - 1 - int'($urandom_range(0, span - 1));
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[LEVEL_W-1:0];
    endfunction

    function automatic logic signed [LEVEL_W-1:0] moderate_level();
        int v;
        v = int'($urandom_range(0, 4000)) - 2000;
        return v[LEVEL_W-1:0];
    endfunction

    // Build the next random poll. Until the flight is due to move on, polls
    // hover on the threshold of the current phase; after that they push it
    // across. About one poll in eight is plain noise.
    task automatic compose_poll(
        input  int                        item_no,
        output logic                      lock,
        output logic signed [LEVEL_W-1:0] az,
        output logic signed [LEVEL_W-1:0] vz
    );
        int   goal;
        int   roll;
        logic push;
        goal = 1 + (item_no * 13) / 1350;
        push = int'(seen_phase) < goal;
        roll = $urandom_range(0, 99);
        lock = 1'($urandom_range(0, 1));
        az   = LEVEL_W'($urandom);
        vz   = LEVEL_W'($urandom);
        if (roll < 4)
            tick_now = $urandom;
        else if (push)
            tick_now = tick_now + $urandom_range(1, 700);
        else
            tick_now = tick_now + $urandom_range(0, 30);
        if (roll >= 12)
        begin
            case (seen_phase)
                PH_INIT:           lock = push ? 1'b1 : lock;
                PH_IDLE:           az = steer(launch_lvl, 1'b1, 1'b0, push);
                PH_LAUNCH_DETECT:  az = steer(launch_lvl, 1'b1, 1'b1, push);
                PH_BOOST:          az = steer(coast_lvl, 1'b0, 1'b0, push);
                PH_BURNOUT_DETECT: az = steer(coast_lvl, 1'b0, 1'b1, push);
                PH_COAST:          vz = steer(apogee_lvl, 1'b0, 1'b0, push);
                PH_APOGEE_DETECT:  vz = steer(apogee_lvl, 1'b0, 1'b1, push);
                PH_APOGEE:         vz = steer(drogue_lvl, 1'b1, 1'b0, push);
                PH_DROGUE_DETECT:  vz = steer(drogue_lvl, 1'b1, 1'b1, push);
                PH_DROGUE:         vz = steer(main_lvl, 1'b1, 1'b0, push);
                PH_MAIN_DETECT:    vz = steer(main_lvl, 1'b1, 1'b1, push);
                PH_MAIN:           vz = steer(landed_lvl, 1'b1, 1'b0, push);
                PH_LANDED_DETECT:  vz = steer(landed_lvl, 1'b1, 1'b1, push);
                default: ;
            endcase
        end
    endtask

    // Present one poll word and return at the edge that accepts it. The
    // stall is looked at mid-cycle, where it is settled.
    task automatic send_poll(
        input logic                      lock,
        input logic signed [LEVEL_W-1:0] az,
        input logic signed [LEVEL_W-1:0] vz,
        input logic [TICK_W-1:0]         ticks
    );
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        gps_locked <= lock;
        accel_z    <= az;
        vel_z      <= vz;
        now_ticks  <= ticks;
        do
            @(negedge clk);
        while (in_stall);
        @(posedge clk);
    endtask

    // Stop sending and wait until every predicted word has come back.
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_words != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] word);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= word;
        @(posedge clk);
    endtask

    // Load a full threshold set. Level words carry random upper bits, which
    // the detector must ignore.
    task automatic load_settings(
        input logic signed [LEVEL_W-1:0] la,
        input logic [TICK_W-1:0]         lh,
        input logic signed [LEVEL_W-1:0] ca,
        input logic [TICK_W-1:0]         ch,
        input logic signed [LEVEL_W-1:0] av,
        input logic signed [LEVEL_W-1:0] dv,
        input logic signed [LEVEL_W-1:0] mv,
        input logic signed [LEVEL_W-1:0] lv
    );
        put_reg(REG_LAUNCH_ACCEL_LEVEL, {16'($urandom), la});
        put_reg(REG_LAUNCH_HOLD_TICKS, lh);
        put_reg(REG_COAST_ACCEL_LEVEL, {16'($urandom), ca});
        put_reg(REG_COAST_HOLD_TICKS, ch);
        put_reg(REG_APOGEE_VEL_LEVEL, {16'($urandom), av});
        put_reg(REG_DROGUE_VEL_LEVEL, {16'($urandom), dv});
        put_reg(REG_MAIN_VEL_LEVEL, {16'($urandom), mv});
        put_reg(REG_LANDED_VEL_LEVEL, {16'($urandom), lv});
        cfg_we     <= 1'b0;
        launch_lvl = la;
        coast_lvl  = ca;
        apogee_lvl = av;
        drogue_lvl = dv;
        main_lvl   = mv;
        landed_lvl = lv;
    endtask

    initial
    begin
        logic                      lock;
        logic signed [LEVEL_W-1:0] az;
        logic signed [LEVEL_W-1:0] vz;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed flight start on the reset thresholds (launch level 768,
        // hold 1000): no lock, lock, level equal to threshold, fall back, hold
        // equal over a tick wrap, fall back before hold check, field extremes.
        send_poll(1'b0, LEVEL_MIN, LEVEL_MAX, 32'd0);
        send_poll(1'b0, LEVEL_MAX, LEVEL_MIN, TICKS_MAX);
        send_poll(1'b1, 16'sd0, 16'sd0, 32'd5);
        send_poll(1'b0, 16'sd768, 16'sd0, 32'd10);
        send_poll(1'b1, 16'sd769, -16'sd1, 32'hFFFF_FF00);
        send_poll(1'b0, 16'sd768, 16'sd1, 32'h0000_02E8);
        send_poll(1'b1, 16'sd767, 16'sd0, 32'h0000_02E9);
        send_poll(1'b0, LEVEL_MAX, LEVEL_MAX, 32'hFFFF_FFF0);
        send_poll(1'b1, 16'sd768, LEVEL_MIN, 32'h0000_03D8);
        send_poll(1'b0, LEVEL_MIN, 16'sd0, 32'h0000_03D9);
        send_poll(1'b1, LEVEL_MAX, 16'sd0, 32'd100);
        send_poll(1'b1, LEVEL_MAX, 16'sd0, 32'd1100);
        send_poll(1'b0, LEVEL_MIN, 16'sd0, 32'd1101);
        settle();

        // Random flight in four stretches, each on its own threshold set.
        tick_now = $urandom;
        for (int item_no = 0; item_no < RANDOM_POLLS; item_no++)
        begin
            if (item_no % STRETCH_LEN == 0)
            begin
                settle();
                case (item_no / STRETCH_LEN)
                    0: load_settings(moderate_level(), $urandom_range(0, 3000),
                                     moderate_level(), $urandom_range(0, 3000),
                                     moderate_level(), moderate_level(),
                                     moderate_level(), moderate_level());
                    1: load_settings(LEVEL_MIN, 32'd0, LEVEL_MAX, TICKS_MAX,
                                     LEVEL_MIN, LEVEL_MAX, LEVEL_MIN, LEVEL_MAX);
                    2: load_settings(LEVEL_MAX, TICKS_MAX, LEVEL_MIN, 32'd0,
                                     LEVEL_MAX, LEVEL_MIN, LEVEL_MAX, LEVEL_MIN);
                    default:
                    begin
                        load_settings(moderate_level(), $urandom_range(0, 1500),
                                      moderate_level(), $urandom_range(0, 1500),
                                      moderate_level(), moderate_level(),
                                      moderate_level(), moderate_level());
                        // Start near the top so the detect timers see a wrap.
                        tick_now = 32'hFFFF_FC00;
                    end
                endcase
                @(posedge clk);
            end
            calm = (item_no >= CALM_FROM);
            compose_poll(item_no, lock, az, vz);
            send_poll(lock, az, vz, tick_now);
        end
        settle();
        repeat (8) @(posedge clk);

        if (mismatch_count == 0 && pending_words == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/fpd_pkg.sv
rtl/fpd_cfg_regs.sv
rtl/fpd_phase_core.sv
rtl/flight_phase_detector.sv
bench/flight_phase_checker.sv
bench/flight_phase_detector_test.sv
